// ===== rtl/h75rs_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// h75rs_pkg: shared types and constants for the panel remap and scan block
// Request and result payloads, queue entry format and sizing constants.
// ----------------------------------------------------------------------------
package h75rs_pkg;

    localparam int PANELS_ACROSS_DEF = 10;
    localparam int PANELS_DOWN_DEF   = 4;

    localparam int PANEL_W        = 32;
    localparam int PANEL_H        = 16;
    localparam int LINES_PER_SCAN = 4;
    localparam int OUT_CHANNELS   = 8;
    localparam int COLOR_W        = 3;
    localparam int POS_W          = 10;
    localparam int ADDR_W         = 12;
    localparam int BANK_W         = 3;
    localparam int QUEUE_DEPTH    = 2;

    localparam logic KIND_WRITE = 1'b0;
    localparam logic KIND_SHIFT = 1'b1;

    typedef enum logic {
        OP_WRITE,
        OP_SHIFT
    } op_t;

    typedef struct packed {
        logic        kind;
        logic [8:0]  pixel_x;
        logic [5:0]  pixel_y;
        logic [2:0]  color;
        logic [1:0]  scan_line;
    } req_t;

    typedef struct packed {
        logic [7:0]  red_lines;
        logic [7:0]  green_lines;
        logic [7:0]  blue_lines;
        logic        line_done;
    } rsp_t;

    typedef struct packed {
        op_t                  op;
        logic [BANK_W-1:0]    bank;
        logic [ADDR_W-1:0]    addr;
        logic [COLOR_W-1:0]   color;
        logic                 done;
    } entry_t;

    typedef struct packed {
        logic   valid;
        entry_t entry;
    } qslot_t;

endpackage

// ===== rtl/h75rs_ram.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// h75rs_ram: single port RAM with registered read
// One write or one read per cycle; read data appears after the clock edge.
// ----------------------------------------------------------------------------
module h75rs_ram #(
    parameter int WIDTH = 3,
    parameter int DEPTH = 2560
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] addr,
    input  logic [WIDTH-1:0]         wdata,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[addr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[addr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ===== rtl/h75rs_front.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// h75rs_front: request decode and address remap
// Turns pixel writes into bank/address form, drops off-screen writes, and
// tracks the shared shift position for shift requests.
// ----------------------------------------------------------------------------
module h75rs_front #(
    parameter int PANELS_ACROSS = h75rs_pkg::PANELS_ACROSS_DEF,
    parameter int PANELS_DOWN   = h75rs_pkg::PANELS_DOWN_DEF
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              accept,
    input  h75rs_pkg::req_t   request,
    output h75rs_pkg::qslot_t push
);
    import h75rs_pkg::*;

    localparam int SCREEN_W    = PANELS_ACROSS * PANEL_W;
    localparam int SCREEN_H    = PANELS_DOWN * PANEL_H;
    localparam int LINE_PIXELS = PANELS_ACROSS * 64;

    localparam logic [ADDR_W-1:0] LINE_PIX_A = ADDR_W'(LINE_PIXELS);
    localparam logic [POS_W-1:0]  LAST_POS   = POS_W'(LINE_PIXELS - 1);

    logic [POS_W-1:0]  shift_pos_reg;
    logic [POS_W-1:0]  shift_pos_next;
    logic              is_shift;
    logic              on_screen;
    logic              at_end;
    logic [1:0]        line;
    logic [POS_W-1:0]  pos;

    assign is_shift  = (request.kind == KIND_SHIFT);
    assign on_screen = ({1'b0, request.pixel_x} < 10'(SCREEN_W)) &&
                       ({2'b00, request.pixel_y} < 8'(SCREEN_H));
    assign at_end    = (shift_pos_reg == LAST_POS);

    always_comb
    begin
        if (is_shift)
        begin
            line = request.scan_line;
            pos  = shift_pos_reg;
        end
        else
        begin
            line = request.pixel_y[1:0];
            pos  = {request.pixel_x[8:3], request.pixel_y[2], request.pixel_x[2:0]};
        end
    end

    always_comb
    begin
        push.valid       = accept && (is_shift || on_screen);
        push.entry.op    = is_shift ? OP_SHIFT : OP_WRITE;
        push.entry.bank  = request.pixel_y[5:3];
        push.entry.addr  = ADDR_W'(ADDR_W'(line) * LINE_PIX_A) + ADDR_W'(pos);
        push.entry.color = request.color;
        push.entry.done  = at_end;
    end

    always_comb
    begin
        shift_pos_next = shift_pos_reg;
        if (accept && is_shift)
        begin
            shift_pos_next = at_end ? '0 : shift_pos_reg + POS_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            shift_pos_reg <= '0;
        end
        else
        begin
            shift_pos_reg <= shift_pos_next;
        end
    end

endmodule

// ===== rtl/h75rs_queue.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// h75rs_queue: short request queue between decode and the frame store
// Register-based FIFO; full drives busy back to the requester.
// ----------------------------------------------------------------------------
module h75rs_queue (
    input  logic              clk,
    input  logic              rst_n,
    input  h75rs_pkg::qslot_t push,
    input  logic              pop,
    output h75rs_pkg::qslot_t head,
    output logic              full
);
    import h75rs_pkg::*;

    localparam int PTR_W = $clog2(QUEUE_DEPTH);
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    entry_t             slots_reg [QUEUE_DEPTH];
    logic [PTR_W-1:0]   wr_ptr_reg;
    logic [PTR_W-1:0]   wr_ptr_next;
    logic [PTR_W-1:0]   rd_ptr_reg;
    logic [PTR_W-1:0]   rd_ptr_next;
    logic [CNT_W-1:0]   count_reg;
    logic [CNT_W-1:0]   count_next;
    logic               do_push;
    logic               do_pop;

    assign full       = (count_reg == CNT_W'(QUEUE_DEPTH));
    assign do_push    = push.valid && !full;
    assign do_pop     = pop && (count_reg != '0);
    assign head.valid = (count_reg != '0);
    assign head.entry = slots_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_reg + PTR_W'(1);
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_reg + PTR_W'(1);
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + CNT_W'(1);
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - CNT_W'(1);
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            slots_reg[wr_ptr_reg] <= push.entry;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

// ===== rtl/h75rs_back.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// h75rs_back: banked frame store and scan output
// One RAM bank per used channel; a shift reads all banks at one address.
// ----------------------------------------------------------------------------
module h75rs_back #(
    parameter int PANELS_ACROSS = h75rs_pkg::PANELS_ACROSS_DEF,
    parameter int PANELS_DOWN   = h75rs_pkg::PANELS_DOWN_DEF
) (
    input  logic              clk,
    input  logic              rst_n,
    input  h75rs_pkg::qslot_t head,
    output logic              pop,
    output logic              result_valid,
    output h75rs_pkg::rsp_t   result
);
    import h75rs_pkg::*;

    localparam int CHANNELS  = PANELS_DOWN * 2;
    localparam int NBANK     = (CHANNELS < OUT_CHANNELS) ? CHANNELS : OUT_CHANNELS;
    localparam int BANK_DEPTH = PANELS_ACROSS * 256;
    localparam int AW        = $clog2(BANK_DEPTH);

    logic [COLOR_W-1:0] rd_color [OUT_CHANNELS];
    logic               is_write;
    logic               is_read;
    logic               valid_reg;
    logic               valid_next;
    logic               done_reg;
    logic               done_next;

    assign pop      = head.valid;
    assign is_write = head.valid && (head.entry.op == OP_WRITE);
    assign is_read  = head.valid && (head.entry.op == OP_SHIFT);

    for (genvar b = 0; b < OUT_CHANNELS; b++)
    begin : g_bank
        if (b < NBANK)
        begin : g_ram
            h75rs_ram #(
                .WIDTH (COLOR_W),
                .DEPTH (BANK_DEPTH)
            ) u_ram (
                .clk   (clk),
                .we    (is_write && (head.entry.bank == BANK_W'(b))),
                .re    (is_read),
                .addr  (head.entry.addr[AW-1:0]),
                .wdata (head.entry.color),
                .rdata (rd_color[b])
            );
        end
        else
        begin : g_none
            assign rd_color[b] = '0;
        end
        assign result.red_lines[b]   = rd_color[b][0];
        assign result.green_lines[b] = rd_color[b][1];
        assign result.blue_lines[b]  = rd_color[b][2];
    end

    assign valid_next       = is_read;
    assign done_next        = is_read ? head.entry.done : done_reg;
    assign result_valid     = valid_reg;
    assign result.line_done = done_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
            done_reg  <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
            done_reg  <= done_next;
        end
    end

endmodule

// ===== rtl/hub75_frame_remap_and_scan.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hub75_frame_remap_and_scan: HUB75 frame store remap and scan driver
// Pixel writes go to a channel-banked frame store in panel scan order;
// shift requests read one pixel position from all eight channels at once.
// ----------------------------------------------------------------------------
// A request is taken on any cycle with start high and busy low, one per
// cycle. A write is stored in the frame store and gives no result. A
// shift's result is registered first in the queue and then in the bank
// read, and is held for a single cycle with result_valid high; the
// receiver must take it then. Each frame store bank has one port, used by
// one request per cycle, so the block sustains one request per clock and
// busy stays low in normal use. The shift position is shared by all scan
// lines and wraps after the last pixel of a line, where line_done is set.
// Read only positions written since power-up.
// ----------------------------------------------------------------------------
module hub75_frame_remap_and_scan #(
    parameter int PANELS_ACROSS = h75rs_pkg::PANELS_ACROSS_DEF,
    parameter int PANELS_DOWN   = h75rs_pkg::PANELS_DOWN_DEF
) (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            start,
    output logic            busy,
    input  h75rs_pkg::req_t request,
    output logic            result_valid,
    output h75rs_pkg::rsp_t result
);
    import h75rs_pkg::*;

    qslot_t push;
    qslot_t head;
    logic   pop;
    logic   accept;

    assign accept = start && !busy;

    h75rs_front #(
        .PANELS_ACROSS (PANELS_ACROSS),
        .PANELS_DOWN   (PANELS_DOWN)
    ) u_front (
        .clk     (clk),
        .rst_n   (rst_n),
        .accept  (accept),
        .request (request),
        .push    (push)
    );

    h75rs_queue u_queue (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (push),
        .pop   (pop),
        .head  (head),
        .full  (busy)
    );

    h75rs_back #(
        .PANELS_ACROSS (PANELS_ACROSS),
        .PANELS_DOWN   (PANELS_DOWN)
    ) u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .head         (head),
        .pop          (pop),
        .result_valid (result_valid),
        .result       (result)
    );

`ifndef SYNTHESIS
    a_shift_gives_result: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy && request.kind == KIND_SHIFT) |-> ##2 result_valid)
        else $error("shift request lost");

    a_result_has_shift: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> $past(start && !busy && request.kind == KIND_SHIFT, 2))
        else $error("result without shift request");

    a_queue_drains: assert property (@(posedge clk) disable iff (!rst_n)
        !busy)
        else $error("request queue filled up");
`endif

endmodule

// ===== tb/hub75_frame_remap_and_scan_test.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hub75_frame_remap_and_scan_test: self-checking bench for the panel scan block
// Preloads the whole frame store, then runs a short directed set and random
// write/shift traffic. Every scan result is checked against a frame store
// model that holds the panel address remap and the shared shift position.
// ----------------------------------------------------------------------------
module hub75_frame_remap_and_scan_test;
    import h75rs_pkg::*;

    localparam int SCREEN_W           = PANELS_ACROSS_DEF * PANEL_W;
    localparam int SCREEN_H           = PANELS_DOWN_DEF * PANEL_H;
    localparam int STORE_DEPTH        = SCREEN_W * SCREEN_H;
    localparam int CHANNELS           = PANELS_DOWN_DEF * 2;
    localparam int PIXELS_PER_CHANNEL = STORE_DEPTH / CHANNELS;
    localparam int LINE_PIXELS        = PIXELS_PER_CHANNEL / LINES_PER_SCAN;
    localparam int GROUPS_PER_ROW     = PANELS_ACROSS_DEF * 4;
    localparam int GROUP_PIXELS       = 16;
    localparam int WATCHDOG_LIMIT     = 2000;

    class frame_scan_model;
        bit [COLOR_W-1:0] pixels [STORE_DEPTH];
        bit [POS_W-1:0]   line_pos;
        rsp_t             expected_scans [$];
        int unsigned      mismatches;
        int unsigned      checked;
        int unsigned      writes_taken;
        int unsigned      writes_dropped;
        int unsigned      shifts_taken;
        int unsigned      lines_closed;

        function int unsigned store_index(int unsigned x, int unsigned y);
            int unsigned grp;
            grp = ((y / 8) * 4 + (y % 4)) * GROUPS_PER_ROW + x / 8;
            return ((y / 4) % 2) * 8 + (x % 8) + grp * GROUP_PIXELS;
        endfunction

        function int unsigned next_read_index(bit [1:0] line, int unsigned ch);
            return line * LINE_PIXELS + line_pos + ch * PIXELS_PER_CHANNEL;
        endfunction

        function int unsigned pending();
            return expected_scans.size();
        endfunction

        function void take_request(req_t r);
            rsp_t             scan;
            int unsigned      idx;
            int unsigned      ch;
            bit [COLOR_W-1:0] px;
            if (r.kind == KIND_WRITE)
            begin
                if (r.pixel_x < SCREEN_W && r.pixel_y < SCREEN_H)
                begin
                    pixels[store_index(r.pixel_x, r.pixel_y)] = r.color;
                    writes_taken++;
                end
                else
                    writes_dropped++;
            end
            else
            begin
                scan = '0;
                for (ch = 0; ch < OUT_CHANNELS && ch < CHANNELS; ch++)
                begin
                    idx = next_read_index(r.scan_line, ch);
                    px  = (idx < STORE_DEPTH) ? pixels[idx] : '0;
                    scan.red_lines[ch]   = px[0];
                    scan.green_lines[ch] = px[1];
                    scan.blue_lines[ch]  = px[2];
                end
                scan.line_done = (line_pos + 1 >= LINE_PIXELS);
                line_pos = scan.line_done ? '0 : line_pos + 1'b1;
                lines_closed += scan.line_done;
                shifts_taken++;
                expected_scans.push_back(scan);
            end
        endfunction

        function void compare(string field, logic [7:0] want, logic [7:0] got);
            if (got !== want)
            begin
                $display("%0t ns: %s expected %h got %h", $time, field, want, got);
                mismatches++;
            end
        endfunction

        function void check_scan(rsp_t got);
            rsp_t want;
            if (expected_scans.size() == 0)
            begin
                $display("%0t ns: unexpected result, expected none got %h", $time, got);
                mismatches++;
                return;
            end
            want = expected_scans.pop_front();
            checked++;
            compare("red_lines", want.red_lines, got.red_lines);
            compare("green_lines", want.green_lines, got.green_lines);
            compare("blue_lines", want.blue_lines, got.blue_lines);
            compare("line_done", 8'(want.line_done), 8'(got.line_done));
        endfunction
    endclass

    logic clk;
    logic rst_n;
    logic start;
    logic busy;
    req_t request;
    logic result_valid;
    rsp_t result;

    frame_scan_model model;
    int unsigned     idle_pct;
    int unsigned     quiet_cycles;
    bit [1:0]        cur_line;

    hub75_frame_remap_and_scan u_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .busy         (busy),
        .request      (request),
        .result_valid (result_valid),
        .result       (result)
    );

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (result_valid)
                model.check_scan(result);
            if ((start && !busy) || result_valid)
                quiet_cycles <= 0;
            else
                quiet_cycles <= quiet_cycles + 1;
        end
    end

    initial
    begin
        while (quiet_cycles < WATCHDOG_LIMIT)
            @(posedge clk);
        $display("%0t ns: no request or result for %0d cycles", $time, WATCHDOG_LIMIT);
        $display("** hub75_frame_remap_and_scan: FAILED **");
        $finish;
    end

    function automatic req_t pixel_write(int unsigned x, int unsigned y, bit [2:0] c);
        req_t r;
        r           = '0;
        r.kind      = KIND_WRITE;
        r.pixel_x   = x[8:0];
        r.pixel_y   = y[5:0];
        r.color     = c;
        r.scan_line = 2'($urandom_range(3));
        return r;
    endfunction

    // inverse of the panel remap: store index back to screen position
    function automatic req_t write_at_index(int unsigned a, bit [2:0] c);
        int unsigned grp;
        int unsigned row;
        grp = a / GROUP_PIXELS;
        row = grp / GROUPS_PER_ROW;
        return pixel_write((grp % GROUPS_PER_ROW) * 8 + a % 8,
                           (row / 4) * 8 + ((a % GROUP_PIXELS) / 8) * 4 + row % 4, c);
    endfunction

    function automatic req_t line_shift(bit [1:0] line);
        req_t r;
        r           = '0;
        r.kind      = KIND_SHIFT;
        r.pixel_x   = 9'($urandom_range(511));
        r.pixel_y   = 6'($urandom_range(63));
        r.color     = 3'($urandom_range(7));
        r.scan_line = line;
        return r;
    endfunction

    task automatic send_request(input req_t r);
        while ($urandom_range(99) < idle_pct)
        begin
            start <= 1'b0;
            @(posedge clk);
        end
        start   <= 1'b1;
        request <= r;
        do
            @(posedge clk);
        while (busy);
        model.take_request(r);
    endtask

    task automatic drain_scans();
        start <= 1'b0;
        do
            @(posedge clk);
        while (model.pending() != 0);
    endtask

    task automatic run_directed();
        int unsigned k;
        send_request(pixel_write(0, 1, 3'd0));
        send_request(pixel_write(SCREEN_W, 0, 3'd7));
        send_request(pixel_write(511, 63, 3'd7));
        send_request(pixel_write(0, 0, 3'd7));
        send_request(pixel_write(SCREEN_W - 1, SCREEN_H - 1, 3'd5));
        send_request(line_shift(2'd1));
        send_request(line_shift(2'd0));
        send_request(line_shift(2'd3));
        send_request(line_shift(2'd2));
        for (k = 0; k < 8; k++)
            send_request(write_at_index(model.next_read_index(2'd1, k), k[2:0]));
        send_request(line_shift(2'd1));
        send_request(write_at_index(model.next_read_index(2'd0, 7), 3'd6));
        send_request(line_shift(2'd0));
        send_request(line_shift(2'd0));
    endtask

    task automatic run_random(input int unsigned count, input int unsigned pct);
        int unsigned n;
        int unsigned pick;
        idle_pct = pct;
        for (n = 0; n < count; n++)
        begin
            if ($urandom_range(99) == 0)
                drain_scans();
            pick = $urandom_range(99);
            if (pick < 75)
            begin
                if ($urandom_range(99) < 30)
                    cur_line = 2'($urandom_range(3));
                send_request(line_shift(cur_line));
            end
            else if (pick < 85)
                send_request(write_at_index(
                    model.next_read_index(cur_line, $urandom_range(CHANNELS - 1)),
                    3'($urandom_range(7))));
            else if (pick < 96)
                send_request(pixel_write($urandom_range(SCREEN_W - 1),
                                         $urandom_range(SCREEN_H - 1),
                                         3'($urandom_range(7))));
            else
                send_request(pixel_write($urandom_range(511), $urandom_range(63),
                                         3'($urandom_range(7))));
        end
        drain_scans();
    endtask

    initial
    begin
        int unsigned x;
        int unsigned y;
        model        = new();
        rst_n        = 1'b0;
        start        = 1'b0;
        request      = '0;
        quiet_cycles = 0;
        cur_line     = '0;
        idle_pct     = 29;
        repeat (12)
            @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // every entry is written before any shift reads it
        for (y = 0; y < SCREEN_H; y++)
            for (x = 0; x < SCREEN_W; x++)
                send_request(pixel_write(x, y, 3'($urandom_range(7))));
        drain_scans();

        run_directed();
        drain_scans();

        run_random(434, 29);
        run_random(433, 60);
        run_random(433, 0);

        repeat (10)
            @(posedge clk);

        $display("Covered %0d pixel writes (%0d off screen) and %0d shifts with %0d line wraps;",
                 model.writes_taken, model.writes_dropped, model.shifts_taken,
                 model.lines_closed);
        $display("%0d scan results checked against the frame store model.", model.checked);
        if (model.mismatches == 0 && model.pending() == 0)
            $display("** hub75_frame_remap_and_scan: PASSED **");
        else
            $display("** hub75_frame_remap_and_scan: FAILED **");
        $finish;
    end

endmodule
